// File: src/pdis_pkg.sv
// Package for the PID controller with deadband and integral separation.
// Holds fixed-point widths, limits and configuration register indexes.
// No dependencies.
`default_nettype none

package pdis_pkg;

    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 24;
    localparam int ERR_W    = 25;
    localparam int DIFF_W   = 26;
    localparam int SUM_W    = 32;
    localparam int DRIVE_W  = 19;
    localparam int PP_W     = GAIN_W + ERR_W;
    localparam int PI_W     = GAIN_W + SUM_W;
    localparam int PD_W     = GAIN_W + DIFF_W;
    localparam int ACC_W    = PI_W + 2;
    localparam int GAIN_FRAC = 12;

    typedef logic [1:0] t_reg_idx;

    localparam t_reg_idx REG_SETPOINT = 2'd0;
    localparam t_reg_idx REG_GAIN_P   = 2'd1;
    localparam t_reg_idx REG_GAIN_I   = 2'd2;
    localparam t_reg_idx REG_GAIN_D   = 2'd3;

    localparam logic signed [ERR_W-1:0] DEADBAND_POS   = 25'sd256;
    localparam logic signed [ERR_W-1:0] DEADBAND_NEG   = -25'sd256;
    localparam logic signed [ERR_W-1:0] SEPARATION_POS = 25'sd1536;
    localparam logic signed [ERR_W-1:0] SEPARATION_NEG = -25'sd1536;

    localparam logic signed [ACC_W-1:0] LIMIT_POS_Q20 = 58'sd838860800;
    localparam logic signed [ACC_W-1:0] LIMIT_NEG_Q20 = -58'sd838860800;
    localparam logic signed [DRIVE_W-1:0] LIMIT_POS_Q8 = 19'sd204800;
    localparam logic signed [DRIVE_W-1:0] LIMIT_NEG_Q8 = -19'sd204800;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7fff_ffff;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

endpackage

`default_nettype wire

// File: src/pid_deadband_integral_separation_top.sv
// Top level of the positional PID controller with deadband and integral separation.
// Five-stage pipeline: input, error and state update, products, sum, clamp.
// Depends on pdis_pkg.
//
//  channel   signals                                        direction
//  input     i_valid, o_stall, i_measured                   in
//  result    o_valid, i_stall, o_drive, o_clamped           out
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data  in
//
// One item is taken per cycle while o_stall is low.
// The error, integral sum and previous error are updated in the second stage.
// Reset clears the gains, setpoint, integral state and all valid bits.
// The input stalls in the same cycle only when every stage holds an item and the output waits.
`default_nettype none

module pid_deadband_integral_separation_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic signed [pdis_pkg::SAMPLE_W-1:0] i_measured,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed [pdis_pkg::DRIVE_W-1:0]       o_drive,
    output logic                                      o_clamped,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire pdis_pkg::t_reg_idx                   i_cfg_index,
    input  wire logic [pdis_pkg::GAIN_W-1:0]          i_cfg_data
);
    import pdis_pkg::*;

    logic signed [SAMPLE_W-1:0] r_setpoint;
    logic signed [GAIN_W-1:0]   r_gain_p;
    logic signed [GAIN_W-1:0]   r_gain_i;
    logic signed [GAIN_W-1:0]   r_gain_d;

    logic signed [ERR_W-1:0]    r_prev;
    logic signed [SUM_W-1:0]    r_sum;

    logic                       r_v0;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       r_vo;
    logic signed [SAMPLE_W-1:0] r_meas;
    logic signed [ERR_W-1:0]    r_e;
    logic signed [SUM_W-1:0]    r_s;
    logic signed [DIFF_W-1:0]   r_de;
    logic signed [PP_W-1:0]     r_pp;
    logic signed [PI_W-1:0]     r_pi;
    logic signed [PD_W-1:0]     r_pd;
    logic signed [ACC_W-1:0]    r_acc;
    logic signed [DRIVE_W-1:0]  r_drive;
    logic                       r_clamped;

    logic adv_o, adv3, adv2, adv1, adv0;

    logic signed [ERR_W-1:0]    e_raw;
    logic                       in_dead;
    logic signed [ERR_W-1:0]    n_e;
    logic signed [SUM_W-1:0]    sum_base;
    logic signed [ERR_W-1:0]    prev_base;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [DIFF_W-1:0]   n_de;
    logic signed [PP_W-1:0]     n_pp;
    logic signed [PI_W-1:0]     n_pi;
    logic signed [PD_W-1:0]     n_pd;
    logic signed [ACC_W-1:0]    n_acc;
    logic signed [DRIVE_W-1:0]  n_drive;
    logic                       n_clamped;

    assign adv_o = !r_vo || !i_stall;
    assign adv3  = !r_v3 || adv_o;
    assign adv2  = !r_v2 || adv3;
    assign adv1  = !r_v1 || adv2;
    assign adv0  = !r_v0 || adv1;

    assign o_stall     = !adv0;
    assign o_valid     = r_vo;
    assign o_drive     = r_drive;
    assign o_clamped   = r_clamped;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint <= '0;
            r_gain_p   <= '0;
            r_gain_i   <= '0;
            r_gain_d   <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SETPOINT: r_setpoint <= i_cfg_data;
                REG_GAIN_P:   r_gain_p   <= i_cfg_data;
                REG_GAIN_I:   r_gain_i   <= i_cfg_data;
                REG_GAIN_D:   r_gain_d   <= i_cfg_data;
                default:      r_setpoint <= r_setpoint;
            endcase
        end
    end

    always_comb begin
        e_raw     = ERR_W'(r_setpoint) - ERR_W'(r_meas);
        in_dead   = (e_raw < DEADBAND_POS) && (e_raw > DEADBAND_NEG);
        n_e       = in_dead ? '0 : e_raw;
        sum_base  = in_dead ? '0 : r_sum;
        prev_base = in_dead ? '0 : r_prev;
        sum_wide  = (SUM_W+1)'(sum_base) + (SUM_W+1)'(n_e);
        if ((n_e < SEPARATION_POS) && (n_e > SEPARATION_NEG)) begin
            if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
                n_sum = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
                n_sum = sum_wide[SUM_W-1:0];
            end
        end else begin
            n_sum = '0;
        end
        n_de = DIFF_W'(n_e) - DIFF_W'(prev_base);
    end

    always_comb begin
        n_pp = PP_W'(r_gain_p) * PP_W'(r_e);
        n_pi = PI_W'(r_gain_i) * PI_W'(r_s);
        n_pd = PD_W'(r_gain_d) * PD_W'(r_de);
        n_acc = ACC_W'(r_pp) + ACC_W'(r_pi) + ACC_W'(r_pd);
    end

    always_comb begin
        if (r_acc > LIMIT_POS_Q20) begin
            n_drive   = LIMIT_POS_Q8;
            n_clamped = 1'b1;
        end else if (r_acc < LIMIT_NEG_Q20) begin
            n_drive   = LIMIT_NEG_Q8;
            n_clamped = 1'b1;
        end else begin
            n_drive   = r_acc[GAIN_FRAC+DRIVE_W-1:GAIN_FRAC];
            n_clamped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0   <= 1'b0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_vo   <= 1'b0;
            r_prev <= '0;
            r_sum  <= '0;
        end else begin
            if (adv0) begin
                r_v0 <= i_valid;
            end
            if (adv1) begin
                r_v1 <= r_v0;
                if (r_v0) begin
                    r_prev <= n_e;
                    r_sum  <= n_sum;
                end
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv_o) begin
                r_vo <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv0) begin
            r_meas <= i_measured;
        end
        if (adv1) begin
            r_e  <= n_e;
            r_s  <= n_sum;
            r_de <= n_de;
        end
        if (adv2) begin
            r_pp <= n_pp;
            r_pi <= n_pi;
            r_pd <= n_pd;
        end
        if (adv3) begin
            r_acc <= n_acc;
        end
        if (adv_o) begin
            r_drive   <= n_drive;
            r_clamped <= n_clamped;
        end
    end

    a_clamp_at_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_clamped) |-> (o_drive == LIMIT_POS_Q8 || o_drive == LIMIT_NEG_Q8))
        else $error("clamped result not at the drive limit");

    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_drive <= LIMIT_POS_Q8 && o_drive >= LIMIT_NEG_Q8))
        else $error("drive outside the limit range");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && r_v0 && r_v1 && r_v2 && r_v3))
        else $error("input stalled while the pipeline has room");

    a_sum_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && (r_e >= SEPARATION_POS || r_e <= SEPARATION_NEG)) |-> (r_s == '0))
        else $error("integral sum kept outside the separation band");

endmodule

`default_nettype wire

// File: tb/pid_deadband_integral_separation_top_test.sv
// Self-checking testbench for pid_deadband_integral_separation_top.
// Predicts every drive item from its own copy of the controller state; uses pdis_pkg.
// Covers directed fixed-point edges, integral windup and random traffic with idling.
`default_nettype none

module pid_deadband_integral_separation_top_test;

    import pdis_pkg::*;

    localparam longint DEADBAND_Q8     = 256;
    localparam longint SEPARATION_Q8   = 1536;
    localparam longint DRIVE_LIMIT_Q8  = 204800;
    localparam longint DRIVE_LIMIT_Q20 = 204800 * 4096;
    localparam longint SUM_HIGH        = 64'sd2147483647;
    localparam longint SUM_LOW         = -64'sd2147483648;
    localparam int     PIPE_DRAIN      = 10;
    localparam int     WINDUP_STEPS    = 60;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic                      clamped;
    } t_drive;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_valid     = 1'b0;
    logic signed [SAMPLE_W-1:0] i_measured  = '0;
    logic                       i_stall     = 1'b0;
    logic                       i_cfg_valid = 1'b0;
    t_reg_idx                   i_cfg_index = REG_SETPOINT;
    logic [GAIN_W-1:0]          i_cfg_data  = '0;
    logic                       o_stall;
    logic                       o_valid;
    logic signed [DRIVE_W-1:0]  o_drive;
    logic                       o_clamped;
    logic                       o_cfg_ready;

    logic signed [SAMPLE_W-1:0] setpoint_q8  = '0;
    logic signed [GAIN_W-1:0]   gain_p_q12   = '0;
    logic signed [GAIN_W-1:0]   gain_i_q12   = '0;
    logic signed [GAIN_W-1:0]   gain_d_q12   = '0;
    longint                     prev_error_q8 = 0;
    longint                     error_sum_q8  = 0;

    t_drive pending_drives[$];
    int     fail_count = 0;
    int     send_idle_pct = 0;
    int     stall_pct = 0;

    pid_deadband_integral_separation_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_measured  (i_measured),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_drive     (o_drive),
        .o_clamped   (o_clamped),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #80_000_000;
        $display("pid_deadband_integral_separation_top_test: errors");
        $finish;
    end

    function automatic void predict_drive(input logic signed [SAMPLE_W-1:0] measured);
        longint err;
        longint sum;
        longint diff;
        longint acc;
        t_drive want;
        err = longint'(setpoint_q8) - longint'(measured);
        if (err < DEADBAND_Q8 && err > -DEADBAND_Q8) begin
            err = 0;
            error_sum_q8 = 0;
            prev_error_q8 = 0;
        end
        if (err < SEPARATION_Q8 && err > -SEPARATION_Q8) begin
            sum = error_sum_q8 + err;
            if (sum > SUM_HIGH) begin
                sum = SUM_HIGH;
            end else if (sum < SUM_LOW) begin
                sum = SUM_LOW;
            end
            error_sum_q8 = sum;
        end else begin
            error_sum_q8 = 0;
        end
        diff = err - prev_error_q8;
        prev_error_q8 = err;
        acc = longint'(gain_p_q12) * err + longint'(gain_i_q12) * error_sum_q8
            + longint'(gain_d_q12) * diff;
        want.clamped = 1'b1;
        if (acc > DRIVE_LIMIT_Q20) begin
            want.drive = DRIVE_W'(DRIVE_LIMIT_Q8);
        end else if (acc < -DRIVE_LIMIT_Q20) begin
            want.drive = DRIVE_W'(-DRIVE_LIMIT_Q8);
        end else begin
            want.drive = DRIVE_W'(acc >>> GAIN_FRAC);
            want.clamped = 1'b0;
        end
        pending_drives.push_back(want);
    endfunction

    function automatic int draw_gap(input int pct);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < pct) begin
            gap++;
        end
        return gap;
    endfunction

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : check_drive
        t_drive want;
        if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
            if (pending_drives.size() == 0) begin
                $error("drive: no item expected, got %0d", o_drive);
                fail_count++;
            end else begin
                want = pending_drives.pop_front();
                if (o_drive !== want.drive) begin
                    $error("drive: expected %0d, got %0d", want.drive, o_drive);
                    fail_count++;
                end
                if (o_clamped !== want.clamped) begin
                    $error("clamped: expected %0d, got %0d", want.clamped, o_clamped);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] measured);
        int gap;
        gap = draw_gap(send_idle_pct);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_measured <= measured;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_drive(measured);
    endtask

    task automatic settle_pipeline();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_drives.size() != 0) @(posedge i_clk);
        repeat (PIPE_DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [GAIN_W-1:0] value);
        settle_pipeline();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            REG_SETPOINT: setpoint_q8 = value;
            REG_GAIN_P:   gain_p_q12  = value;
            REG_GAIN_I:   gain_i_q12  = value;
            REG_GAIN_D:   gain_d_q12  = value;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_controller(input int setpoint, input int kp, input int ki,
                                  input int kd);
        write_reg(REG_SETPOINT, GAIN_W'(setpoint));
        write_reg(REG_GAIN_P, GAIN_W'(kp));
        write_reg(REG_GAIN_I, GAIN_W'(ki));
        write_reg(REG_GAIN_D, GAIN_W'(kd));
    endtask

    task automatic test_reset_defaults();
        send_sample(24'sd8388607);
        send_sample(-24'sd8388608);
        send_sample(24'sd0);
    endtask

    task automatic test_deadband_and_separation_edges();
        set_controller(0, 4096, 4096, 0);
        send_sample(-24'sd255);
        send_sample(24'sd255);
        send_sample(-24'sd256);
        send_sample(24'sd256);
        send_sample(-24'sd1535);
        send_sample(24'sd1535);
        send_sample(-24'sd1536);
        send_sample(24'sd1536);
    endtask

    task automatic test_limits_and_rounding();
        set_controller(0, 4096, 0, 0);
        send_sample(-24'sd204800);
        send_sample(-24'sd204801);
        send_sample(24'sd204800);
        send_sample(24'sd204801);
        set_controller(0, 1, 0, 0);
        send_sample(24'sd300);
        send_sample(-24'sd300);
    endtask

    task automatic test_integral_and_derivative();
        set_controller(0, 0, 4096, 4096);
        send_sample(-24'sd1000);
        send_sample(-24'sd1000);
        send_sample(24'sd1535);
        send_sample(-24'sd1536);
        send_sample(24'sd0);
        send_sample(24'sd500);
    endtask

    task automatic test_error_extremes();
        set_controller(8388607, 8388607, -8388608, 8388607);
        send_sample(-24'sd8388608);
        set_controller(-8388608, -8388608, 8388607, -8388608);
        send_sample(24'sd8388607);
    endtask

    // The integral sum winds up until the drive sits at the positive limit.
    task automatic test_integral_windup();
        send_idle_pct = 0;
        stall_pct = 0;
        set_controller(0, 0, 16384, 0);
        repeat (WINDUP_STEPS) send_sample(-24'sd1535);
        send_sample(24'sd1535);
        send_sample(-24'sd1536);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_measured();
        int     err;
        longint measured;
        case ($urandom_range(9))
            0, 1: return SAMPLE_W'($urandom);
            2: begin
                err = $urandom_range(1) ? 255 + $urandom_range(1) : 1535 + $urandom_range(1);
                if ($urandom_range(1)) begin
                    err = -err;
                end
            end
            default: err = int'($urandom_range(4000)) - 2000;
        endcase
        measured = longint'(setpoint_q8) - err;
        return measured[SAMPLE_W-1:0];
    endfunction

    function automatic int pick_gain(input bit extreme);
        if (extreme) begin
            return $urandom_range(1) ? 8388607 : -8388608;
        end
        return int'($urandom_range(131071)) - 65536;
    endfunction

    task automatic test_random_traffic(input int idle_pct, input int hold_pct,
                                       input int item_count);
        int setpoint;
        bit extreme;
        send_idle_pct = idle_pct;
        stall_pct = hold_pct;
        for (int k = 0; k < 3; k++) begin
            extreme = (k == 2);
            if (extreme) begin
                setpoint = $urandom_range(1) ? 8388607 : -8388608;
            end else begin
                setpoint = int'($urandom);
            end
            set_controller(setpoint, pick_gain(extreme), pick_gain(extreme),
                           pick_gain(extreme));
            repeat (item_count / 3) send_sample(pick_measured());
        end
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_deadband_and_separation_edges();
        test_limits_and_rounding();
        test_integral_and_derivative();
        test_error_extremes();
        test_integral_windup();
        test_random_traffic(0, 0, 270);
        test_random_traffic(71, 0, 270);
        test_random_traffic(0, 71, 270);
        test_random_traffic(35, 35, 270);
        send_idle_pct = 0;
        stall_pct = 0;
        settle_pipeline();
        if (fail_count == 0) begin
            $display("pid_deadband_integral_separation_top_test: clean");
        end else begin
            $display("pid_deadband_integral_separation_top_test: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
